// ===== rtl/pst_pkg.sv =====
package pst_pkg;

  localparam int PALETTES           = 16;
  localparam int COLORS_PER_PALETTE = 4;
  localparam int ITEM_COLORS        = 4;
  localparam int COLOR_W            = 32;
  localparam int COUNT_W            = 3;
  localparam int INDEX_W            = 4;
  // colors an entry can ever hold: the item carries at most four
  localparam int SLOTS   = (COLORS_PER_PALETTE < ITEM_COLORS) ? COLORS_PER_PALETTE : ITEM_COLORS;
  localparam int TOTAL_W = $clog2(PALETTES + 1);

  localparam logic CMD_INSERT = 1'b0;

  typedef struct packed {
    logic                                  active;
    logic                                  cmd;
    logic [ITEM_COLORS-1:0][COLOR_W-1:0]   colors;
    logic [COUNT_W-1:0]                    count;
    logic                                  hit;
    logic                                  added;
    logic [TOTAL_W-1:0]                    idx;
    logic [TOTAL_W-1:0]                    pos;
    logic [TOTAL_W-1:0]                    total;
  } token_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               hit;
    logic               added;
    logic               full;
  } result_t;

endpackage

// ===== rtl/pst_channels.sv =====
interface pst_item_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [pst_pkg::COLOR_W-1:0] color_0;
  logic [pst_pkg::COLOR_W-1:0] color_1;
  logic [pst_pkg::COLOR_W-1:0] color_2;
  logic [pst_pkg::COLOR_W-1:0] color_3;
  logic [pst_pkg::COUNT_W-1:0] color_count;

  modport source(output valid, command, color_0, color_1, color_2, color_3, color_count,
                 input ready);
  modport sink(input valid, command, color_0, color_1, color_2, color_3, color_count,
               output ready);
endinterface

interface pst_result_if;
  logic                        valid;
  logic                        ready;
  logic [pst_pkg::INDEX_W-1:0] palette_index;
  logic                        hit;
  logic                        added;
  logic                        table_full;

  modport source(output valid, palette_index, hit, added, table_full, input ready);
  modport sink(input valid, palette_index, hit, added, table_full, output ready);
endinterface

// ===== rtl/pst_cell.sv =====
module pst_cell (
  input  logic            clk,
  input  logic            rst,
  input  pst_pkg::token_t tok_in,
  output pst_pkg::token_t tok_out
);

  logic [pst_pkg::SLOTS-1:0][pst_pkg::COLOR_W-1:0] colors;
  logic [pst_pkg::COUNT_W-1:0]                     size;
  logic                                            contains;
  logic                                            store;
  pst_pkg::token_t                                 tok_next;

  always_comb begin
    logic has;
    contains = 1'b1;
    for (int k = 0; k < pst_pkg::ITEM_COLORS; k++) begin
      has = 1'b0;
      for (int j = 0; j < pst_pkg::SLOTS; j++) begin
        if ((pst_pkg::COUNT_W'(j) < size) && (colors[j] == tok_in.colors[k])) begin
          has = 1'b1;
        end
      end
      if ((pst_pkg::COUNT_W'(k) < tok_in.count) && !has) begin
        contains = 1'b0;
      end
    end
  end

  always_comb begin
    tok_next     = tok_in;
    tok_next.pos = tok_in.pos + pst_pkg::TOTAL_W'(1);
    store        = 1'b0;
    if (tok_in.active && !tok_in.hit && !tok_in.added) begin
      if ((tok_in.pos < tok_in.total) && contains) begin
        tok_next.hit = 1'b1;
        tok_next.idx = tok_in.pos;
      end else if ((tok_in.pos == tok_in.total) && (tok_in.cmd == pst_pkg::CMD_INSERT)) begin
        // first free entry and nothing earlier matched: claim it
        tok_next.added = 1'b1;
        tok_next.idx   = tok_in.pos;
        store          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      for (int j = 0; j < pst_pkg::SLOTS; j++) begin
        colors[j] <= tok_in.colors[j];
      end
      size <= tok_in.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.cmd    <= tok_next.cmd;
    tok_out.colors <= tok_next.colors;
    tok_out.count  <= tok_next.count;
    tok_out.hit    <= tok_next.hit;
    tok_out.added  <= tok_next.added;
    tok_out.idx    <= tok_next.idx;
    tok_out.pos    <= tok_next.pos;
    tok_out.total  <= tok_next.total;
  end

endmodule

// ===== rtl/palette_subset_table_top.sv =====
// Palette subset table. Stores up to PALETTES palettes of up to four packed
// RGBA colors each, one palette per cell of a chain. An insert beat adds its
// palette as a new entry unless an earlier entry already holds all of its
// colors (then it reports that entry as a hit); with no match and a full
// table it reports table_full and leaves the table alone. A find beat
// returns the lowest entry holding all of its colors, or a miss with index
// 0. An empty palette matches any entry; a color_count above four saturates.
// Each item walks the chain of PALETTES cells, one cell per clock; the next
// item is accepted only once the previous one has left the last cell, and
// its result is then registered. One item is in the chain at a time. A
// result that is not taken is held, and a second one parks in a spare
// register; while the spare is occupied the input stalls, but the chain
// itself never does.
module palette_subset_table_top (
  input  logic          clk,
  input  logic          rst,
  pst_item_if.sink      items,
  pst_result_if.source  results
);

  pst_pkg::token_t  chain [pst_pkg::PALETTES+1];
  pst_pkg::token_t  tail;
  pst_pkg::result_t tail_res;
  pst_pkg::result_t res;
  pst_pkg::result_t spare;
  logic             res_valid;
  logic             spare_valid;
  logic             busy;
  logic             accept;
  logic             take;
  logic [pst_pkg::TOTAL_W-1:0] total;
  logic [pst_pkg::COUNT_W-1:0] count_sat;

  assign items.ready = !busy && !spare_valid;
  assign accept      = items.valid && items.ready;
  assign take        = res_valid && results.ready;

  // Saturate the color count to what an entry can hold.
  assign count_sat = (items.color_count > pst_pkg::COUNT_W'(pst_pkg::SLOTS)) ?
                     pst_pkg::COUNT_W'(pst_pkg::SLOTS) : items.color_count;

  // Inject the accepted beat straight into the head cell.
  always_comb begin
    chain[0].active    = accept;
    chain[0].cmd       = items.command;
    chain[0].colors[0] = items.color_0;
    chain[0].colors[1] = items.color_1;
    chain[0].colors[2] = items.color_2;
    chain[0].colors[3] = items.color_3;
    chain[0].count     = count_sat;
    chain[0].hit       = 1'b0;
    chain[0].added     = 1'b0;
    chain[0].idx       = '0;
    chain[0].pos       = '0;
    chain[0].total     = total;
  end

  for (genvar i = 0; i < pst_pkg::PALETTES; i++) begin : g_cell
    pst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail = chain[pst_pkg::PALETTES];

  // Format the result leaving the last cell; a miss carries index 0.
  always_comb begin
    tail_res.index = pst_pkg::INDEX_W'(tail.idx);
    tail_res.hit   = tail.hit;
    tail_res.added = tail.added;
    tail_res.full  = (tail.cmd == pst_pkg::CMD_INSERT) && !tail.hit && !tail.added;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
      total       <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (tail.active) begin
        // item done: release the chain and count a new entry
        busy <= 1'b0;
        if (tail.added) begin
          total <= total + pst_pkg::TOTAL_W'(1);
        end
      end
      if (take || !res_valid) begin
        if (spare_valid) begin
          res         <= spare;
          res_valid   <= 1'b1;
          spare_valid <= 1'b0;
        end else if (tail.active) begin
          res       <= tail_res;
          res_valid <= 1'b1;
        end else begin
          res_valid <= 1'b0;
        end
      end else if (tail.active) begin
        // output held: park the result
        spare       <= tail_res;
        spare_valid <= 1'b1;
      end
    end
  end

  assign results.valid         = res_valid;
  assign results.palette_index = res.index;
  assign results.hit           = res.hit;
  assign results.added         = res.added;
  assign results.table_full    = res.full;

endmodule

// ===== rtl/pst_checker.sv =====
module pst_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pst_pkg::INDEX_W-1:0] palette_index,
  input logic                        hit,
  input logic                        added,
  input logic                        table_full
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index) && $stable(hit)
                                && $stable(added) && $stable(table_full))
    else $error("stalled result beat changed");

  a_hit_added: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && added))
    else $error("result both hit and added");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !hit && !added && (palette_index == '0))
    else $error("table_full result carries a hit, an add or an index");

  // One item in the chain at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in the chain");

endmodule

bind palette_subset_table_top pst_checker u_pst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .palette_index (results.palette_index),
  .hit           (results.hit),
  .added         (results.added),
  .table_full    (results.table_full)
);
